// ----- rtl/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, codes and defaults for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int unsigned QueueDepthDefault = 16;
    localparam int unsigned TimeWidthDefault  = 32;
    localparam int unsigned IdWidthDefault    = 8;
    localparam int unsigned FifoDepth         = 2;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds on the output channel.
    localparam logic [2:0] EV_EXPIRED   = 3'd0;
    localparam logic [2:0] EV_INSERTED  = 3'd1;
    localparam logic [2:0] EV_CANCELLED = 3'd2;
    localparam logic [2:0] EV_NOT_FOUND = 3'd3;
    localparam logic [2:0] EV_FULL      = 3'd4;
    localparam logic [2:0] EV_DUPLICATE = 3'd5;

    // A command as it travels from the front part to the back part.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] dur;
    } t_cmd;

endpackage

// ----- rtl/delta_list_timer_queue.sv -----
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue kept as an ordered delta list with insert, cancel and tick.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_axis channel. tdata carries the timer id in
// bits 7:0 and the duration in bits 39:8; tuser carries the operation code
// (insert, cancel, tick). Unused operation codes are dropped on entry.
// Results leave on the m_axis channel: tdata holds the id in bits 7:0 and
// the ticks elapsed since insert in bits 39:8 (zero unless cancelled),
// tuser the result kind, and tlast marks the final result of one command.
// A front stage classifies commands into a two-entry queue; the back stage
// walks the list one entry per clock. An insert makes a search pass, then a
// placement and shift pass; a cancel makes a search pass, then a shift
// pass when the id is found. A tick without expiry is handled in the idle
// state and gives no result. Each expired entry is emitted first, and then
// the entries behind it each move down one place to close the gap.
// Reset clears the count, the elapsed counter and the global time; the
// entry storage is not cleared, since only entries below the count are read.
// When the receiver stalls, the result register holds and the back stage
// waits; the front queue still takes up to two further commands.
module delta_list_timer_queue #(
    parameter int unsigned QUEUE_DEPTH = dltq_pkg::QueueDepthDefault,
    parameter int unsigned TIME_WIDTH  = dltq_pkg::TimeWidthDefault,
    parameter int unsigned ID_WIDTH    = dltq_pkg::IdWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // timer_id [7:0], duration [39:8]
    input  logic [1:0]  s_axis_tuser,   // operation [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_id [7:0], elapsed_ticks [39:8]
    output logic [2:0]  m_axis_tuser,   // event_kind [2:0]
    output logic        m_axis_tlast    // last_of_run
);

    dltq_pkg::t_cmd w_in_cmd, w_q_cmd;
    logic           w_q_valid, w_q_ready;
    logic [7:0]     w_id;
    logic [31:0]    w_el;

    // Only the low ID_WIDTH / TIME_WIDTH bits of each field matter.
    assign w_in_cmd.op  = s_axis_tuser;
    assign w_in_cmd.id  = 8'(s_axis_tdata[7:0] & 8'((16'd1 << ID_WIDTH) - 1'b1));
    assign w_in_cmd.dur = 32'(s_axis_tdata[39:8]
                              & 32'((64'd1 << TIME_WIDTH) - 1'b1));

    dltq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (w_in_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    dltq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_ready   (w_q_ready),
        .i_cmd     (w_q_cmd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_id      (w_id),
        .o_elapsed (w_el),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {w_el, w_id};

endmodule

// ----- rtl/dltq_front.sv -----
// ----------------------------------------------------------------------------
// dltq_front
// Accepts input items, drops unused operation codes and queues commands.
// ----------------------------------------------------------------------------
module dltq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dltq_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output dltq_pkg::t_cmd  o_cmd
);

    localparam int unsigned Depth = dltq_pkg::FifoDepth;
    localparam int unsigned AW    = $clog2(Depth);

    dltq_pkg::t_cmd r_mem [Depth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_push, w_pop, w_known;

    assign o_ready = (r_cnt != (AW+1)'(Depth));
    assign w_known = (i_cmd.op == dltq_pkg::OP_INSERT) || (i_cmd.op == dltq_pkg::OP_CANCEL)
                  || (i_cmd.op == dltq_pkg::OP_TICK);
    assign w_push  = i_valid && o_ready && w_known;
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !w_push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != '0) else $error("pop from empty queue");

endmodule

// ----- rtl/dltq_back.sv -----
// ----------------------------------------------------------------------------
// dltq_back
// Sequencer that walks the delta list one entry per cycle and emits results.
// ----------------------------------------------------------------------------
module dltq_back #(
    parameter int unsigned QUEUE_DEPTH = dltq_pkg::QueueDepthDefault,
    parameter int unsigned TIME_WIDTH  = dltq_pkg::TimeWidthDefault,
    parameter int unsigned ID_WIDTH    = dltq_pkg::IdWidthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dltq_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_id,
    output logic [31:0]     o_elapsed,
    output logic            o_last
);

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);
    localparam logic [TIME_WIDTH-1:0] TMax = '1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PLACE, S_SHIFT, S_EXPIRE, S_OUT} t_state;

    // Small register file: each entry is read at the scan index and at
    // neighbor positions of that index during shifts.
    logic [ID_WIDTH-1:0]   r_sid    [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] r_sdelta [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] r_sstart [QUEUE_DEPTH];

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [TIME_WIDTH-1:0] r_helapsed, r_gtime;
    logic [1:0]            r_op;
    logic [ID_WIDTH-1:0]   r_cid;
    logic [TIME_WIDTH-1:0] r_d;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_pos;
    logic                  r_found;
    logic [IW-1:0]         r_fidx;
    logic                  r_ovalid;
    logic [2:0]            r_okind;
    logic [7:0]            r_oid;
    logic [31:0]           r_oel;
    logic                  r_olast;
    logic [CW:0]           r_nres;
    // Result of the current command, held apart from the output register
    // so that a stalled result is never disturbed.
    logic [2:0]            r_rkind;
    logic [31:0]           r_rel;

    logic [IW-1:0]         w_i;
    logic [TIME_WIDTH:0]   w_sum;
    logic [TIME_WIDTH-1:0] w_rem;
    logic                  w_load;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_kind    = r_okind;
    assign o_id      = r_oid;
    assign o_elapsed = r_oel;
    assign o_last    = r_olast;
    assign w_i       = r_idx[IW-1:0];
    assign w_rem     = (r_sdelta[0] > r_helapsed) ? r_sdelta[0] - r_helapsed : '0;
    assign w_sum     = {1'b0, r_sdelta[r_fidx]} + {1'b0, r_sdelta[IW'(r_fidx + 1'b1)]};
    assign w_load    = ((r_state == S_OUT) || (r_state == S_EXPIRE && r_idx == '0))
                    && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_helapsed <= '0;
            r_gtime    <= '0;
            r_ovalid   <= 1'b0;
            r_nres     <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_cmd.op;
                        r_cid   <= ID_WIDTH'(i_cmd.id);
                        r_d     <= TIME_WIDTH'(i_cmd.dur);
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_nres  <= '0;
                        if (i_cmd.op == dltq_pkg::OP_TICK) begin
                            r_gtime <= r_gtime + 1'b1;
                            if (r_count != '0) begin
                                if (r_helapsed + 1'b1 >= r_sdelta[0]) begin
                                    r_state <= S_EXPIRE;
                                end else begin
                                    r_helapsed <= r_helapsed + 1'b1;
                                end
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // Look for the id, one entry per cycle.
                S_SCAN: begin
                    if (r_idx < r_count && !r_found) begin
                        if (r_sid[w_i] == r_cid) begin
                            r_found <= 1'b1;
                            r_fidx  <= w_i;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else if (r_op == dltq_pkg::OP_INSERT) begin
                        if (r_found) begin
                            r_rkind <= dltq_pkg::EV_DUPLICATE;
                            r_state <= S_OUT;
                        end else if (r_count == Full) begin
                            r_rkind <= dltq_pkg::EV_FULL;
                            r_state <= S_OUT;
                        end else if (r_count == '0) begin
                            r_helapsed <= '0;
                            r_pos      <= '0;
                            r_idx      <= '0;
                            r_state    <= S_SHIFT;
                        end else if (r_d < w_rem) begin
                            r_sdelta[0] <= w_rem - r_d;
                            r_helapsed  <= '0;
                            r_pos       <= '0;
                            r_idx       <= r_count;
                            r_state     <= S_SHIFT;
                        end else begin
                            r_d     <= r_d - w_rem;
                            r_idx   <= CW'(1);
                            r_state <= S_PLACE;
                        end
                    end else if (!r_found) begin
                        r_rkind <= dltq_pkg::EV_NOT_FOUND;
                        r_rel   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // Cancel: fold its delta into the successor, then close the gap.
                        r_rel <= 32'(r_gtime - r_sstart[r_fidx]);
                        if (CW'(r_fidx) + 1'b1 < r_count) begin
                            r_sdelta[IW'(r_fidx + 1'b1)] <= w_sum[TIME_WIDTH] ? TMax
                                                            : w_sum[TIME_WIDTH-1:0];
                        end
                        r_idx   <= CW'(r_fidx);
                        r_state <= S_SHIFT;
                    end
                end
                // Walk the deltas to find the insert position.
                S_PLACE: begin
                    if (r_idx >= r_count) begin
                        r_pos   <= r_count;
                        r_idx   <= r_count;
                        r_state <= S_SHIFT;
                    end else if (r_d < r_sdelta[w_i]) begin
                        r_sdelta[w_i] <= r_sdelta[w_i] - r_d;
                        r_pos   <= r_idx;
                        r_idx   <= r_count;
                        r_state <= S_SHIFT;
                    end else begin
                        r_d   <= r_d - r_sdelta[w_i];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // Move one entry per cycle: up for insert, down for cancel.
                S_SHIFT: begin
                    if (r_op == dltq_pkg::OP_INSERT) begin
                        if (r_idx > r_pos) begin
                            r_sid[w_i]    <= r_sid[IW'(r_idx - 1'b1)];
                            r_sdelta[w_i] <= r_sdelta[IW'(r_idx - 1'b1)];
                            r_sstart[w_i] <= r_sstart[IW'(r_idx - 1'b1)];
                            r_idx <= r_idx - 1'b1;
                        end else begin
                            r_sid[w_i]    <= r_cid;
                            r_sdelta[w_i] <= r_d;
                            r_sstart[w_i] <= r_gtime;
                            r_count <= r_count + 1'b1;
                            r_rkind <= dltq_pkg::EV_INSERTED;
                            r_rel   <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        if (r_idx + 1'b1 < r_count) begin
                            r_sid[w_i]    <= r_sid[IW'(r_idx + 1'b1)];
                            r_sdelta[w_i] <= r_sdelta[IW'(r_idx + 1'b1)];
                            r_sstart[w_i] <= r_sstart[IW'(r_idx + 1'b1)];
                            r_idx <= r_idx + 1'b1;
                        end else begin
                            r_count <= r_count - 1'b1;
                            if (r_count == CW'(1)) begin
                                r_helapsed <= '0;
                            end
                            r_rkind <= dltq_pkg::EV_CANCELLED;
                            r_state <= S_OUT;
                        end
                    end
                end
                // Emit the head, then shift the list down one entry a cycle.
                S_EXPIRE: begin
                    if (r_idx == '0) begin
                        if (w_load) begin
                            r_okind  <= dltq_pkg::EV_EXPIRED;
                            r_oid    <= 8'(r_sid[0]);
                            r_oel    <= '0;
                            r_nres   <= r_nres + 1'b1;
                            r_olast  <= !(r_count > CW'(1) && r_sdelta[1] == '0
                                          && r_nres + 1'b1 < (CW+1)'(QUEUE_DEPTH));
                            r_idx    <= CW'(1);
                        end
                    end else if (r_idx < r_count) begin
                        r_sid[IW'(r_idx - 1'b1)]    <= r_sid[w_i];
                        r_sdelta[IW'(r_idx - 1'b1)] <= r_sdelta[w_i];
                        r_sstart[IW'(r_idx - 1'b1)] <= r_sstart[w_i];
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_idx   <= '0;
                        if (r_olast) begin
                            r_helapsed <= '0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_okind  <= r_rkind;
                        r_oid    <= 8'(r_cid);
                        r_oel    <= (r_rkind == dltq_pkg::EV_CANCELLED) ? r_rel : '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full) else $error("entry count beyond depth");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid && $stable(r_okind))
        else $error("result dropped while stalled");
    a_empty_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> r_helapsed == '0)
        else $error("elapsed count nonzero on empty queue");

endmodule
